>>> design/fmt_pkg.sv
// Package for the truncating float32 multiplier.
// Holds field widths, special codes and the per-cell sideband struct.
package fmt_pkg;
	localparam int SIG_W    = 24;
	localparam int PROD_W   = 48;
	localparam int NCELL    = 4;
	localparam int DIGIT_W  = SIG_W / NCELL;
	localparam logic [31:0] INF_CODE = 32'h7F80_0000;
	localparam logic [31:0] NAN_CODE = 32'h7F80_0001;
	localparam logic [7:0]  EXP_ALL  = 8'hFF;
	localparam logic [9:0]  EXP_BIAS = 10'd127;

	typedef struct packed {
		logic        vld;
		logic        spec;
		logic [31:0] spec_val;
		logic        sign;
		logic [9:0]  exp;
	} side_t;
endpackage

>>> design/fmt_if.sv
// Valid/ready channel carrying one 32-bit item.
// Depends on nothing.
interface fmt_stream_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fmt_pair_if;
	logic        valid;
	logic        ready;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

>>> design/fmt_cell.sv
// One multiply cell: adds one 6-bit digit of B times A to the running product.
// Depends on fmt_pkg.
module fmt_cell import fmt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  side_t               side_in,
	input  logic [SIG_W-1:0]    siga_in,
	input  logic [SIG_W-1:0]    sigb_in,
	input  logic [PROD_W-1:0]   acc_in,
	input  logic [1:0]          idx,
	output side_t               side_q,
	output logic [SIG_W-1:0]    siga_q,
	output logic [SIG_W-1:0]    sigb_q,
	output logic [PROD_W-1:0]   acc_q
);
	logic [DIGIT_W-1:0]        digit;
	logic [SIG_W+DIGIT_W-1:0]  part;
	logic [PROD_W-1:0]         part_sh;

	assign digit   = sigb_in[idx*DIGIT_W +: DIGIT_W];
	assign part    = siga_in * digit;
	assign part_sh = {{(PROD_W-SIG_W-DIGIT_W){1'b0}}, part} << (idx*DIGIT_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else if (en) begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			siga_q          <= siga_in;
			sigb_q          <= sigb_in;
			acc_q           <= acc_in + part_sh;
		end
	end
endmodule

>>> design/float32_multiply_truncating_top.sv
// Truncating float32 multiplier, top level; depends on fmt_pkg, fmt_if, fmt_cell.
// Pipeline: 6 register stages (decode, four 24x6 multiply cells, pack).
// Throughput: one item per cycle; the whole chain advances when the output
// register is empty or being taken.
// Reset: arst_n clears valid bits and sideband; datapath registers are not reset.
module float32_multiply_truncating_top import fmt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	fmt_pair_if.sink   in_ch,
	fmt_stream_if.source out_ch
);
	logic  adv;
	side_t side_s1;
	logic [SIG_W-1:0] siga_s1, sigb_s1;
	side_t side_c [NCELL+1];
	logic [SIG_W-1:0] siga_c [NCELL+1];
	logic [SIG_W-1:0] sigb_c [NCELL+1];
	logic [PROD_W-1:0] acc_c [NCELL+1];
	side_t dec;
	logic [7:0] ea, eb;
	logic [22:0] fa, fb;
	logic sgn;
	logic [PROD_W-1:0] prod;
	side_t last;
	logic top;
	logic [9:0] ex;
	logic [31:0] res;
	logic out_vld_q;
	logic [31:0] out_q;

	assign adv = !out_vld_q || out_ch.ready;
	assign in_ch.ready = adv;

	assign ea  = in_ch.operand_a[30:23];
	assign eb  = in_ch.operand_b[30:23];
	assign fa  = in_ch.operand_a[22:0];
	assign fb  = in_ch.operand_b[22:0];
	assign sgn = in_ch.operand_a[31] ^ in_ch.operand_b[31];

	always_comb begin
		dec.vld      = in_ch.valid;
		dec.sign     = sgn;
		dec.exp      = {2'b00, ea} + {2'b00, eb};
		dec.spec     = 1'b1;
		dec.spec_val = {sgn, 31'd0};
		if (ea == EXP_ALL) begin
			dec.spec_val = (fa == 23'd0 && eb != 8'd0) ? (INF_CODE | {sgn, 31'd0}) : NAN_CODE;
		end else if (eb == EXP_ALL) begin
			dec.spec_val = (fb == 23'd0 && ea != 8'd0) ? (INF_CODE | {sgn, 31'd0}) : NAN_CODE;
		end else if (ea != 8'd0 && eb != 8'd0) begin
			dec.spec = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= dec;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			siga_s1          <= {1'b1, fa};
			sigb_s1          <= {1'b1, fb};
		end
	end

	assign side_c[0] = side_s1;
	assign siga_c[0] = siga_s1;
	assign sigb_c[0] = sigb_s1;
	assign acc_c[0]  = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		fmt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.side_in (side_c[i]),
			.siga_in (siga_c[i]),
			.sigb_in (sigb_c[i]),
			.acc_in  (acc_c[i]),
			.idx     (2'(i)),
			.side_q  (side_c[i+1]),
			.siga_q  (siga_c[i+1]),
			.sigb_q  (sigb_c[i+1]),
			.acc_q   (acc_c[i+1])
		);
	end

	assign last = side_c[NCELL];
	assign prod = acc_c[NCELL];
	assign top  = prod[PROD_W-1];
	assign ex   = last.exp - EXP_BIAS + {9'd0, top};

	always_comb begin
		if (last.spec) begin
			res = last.spec_val;
		end else if (ex[9] || ex == 10'd0) begin
			res = {last.sign, 31'd0};
		end else if (ex >= {2'b00, EXP_ALL}) begin
			res = INF_CODE | {last.sign, 31'd0};
		end else begin
			res = {last.sign, ex[7:0],
				top ? prod[46:24] : prod[45:23]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ch.ready |=> out_vld_q && $stable(out_q))
		else $error("output item changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_vld_q |-> in_ch.ready)
		else $error("input stalled with empty output");
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q[30:23] == EXP_ALL && out_q[22:0] != 23'd0 |-> out_q == NAN_CODE)
		else $error("non-canonical NaN");
endmodule
